// ----- rtl/mss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg
// Shared widths, constants, types and decode tables for the seven-segment
// scan core.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int NUMBER_W      = 14;
    localparam int POINTS_W      = 4;
    localparam int MIN_WIDTH_W   = 3;
    localparam int SEL_W         = 4;
    localparam int SEG_W         = 7;
    localparam int NUM_DIGITS_DEF = 4;

    localparam logic [NUMBER_W-1:0] MAX_VALUE_RST = 14'd9999;

    // reciprocal scaling for the constant divides by powers of ten
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = NUMBER_W + RECIP_W;
    localparam int LIM_W       = 17;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef logic [3:0] exp_t;

    // result fields, digit_select in the low bits
    typedef struct packed {
        logic              point_on;
        logic [SEG_W-1:0]  segments;
        logic [SEL_W-1:0]  digit_select;
    } disp_t;

    // ceil(2^28 / 10^e); zero for exponents whose quotient is always zero
    function automatic logic [RECIP_W-1:0] recip_of(input exp_t e);
        logic [RECIP_W-1:0] m;
        case (e)
            4'd0:    m = 29'd268435456;
            4'd1:    m = 29'd26843546;
            4'd2:    m = 29'd2684355;
            4'd3:    m = 29'd268436;
            4'd4:    m = 29'd26844;
            default: m = '0;
        endcase
        return m;
    endfunction

    // 10^e, saturated above any 14-bit number
    function automatic logic [LIM_W-1:0] pow10_lim(input exp_t e);
        logic [LIM_W-1:0] l;
        case (e)
            4'd0:    l = 17'd1;
            4'd1:    l = 17'd10;
            4'd2:    l = 17'd100;
            4'd3:    l = 17'd1000;
            4'd4:    l = 17'd10000;
            default: l = '1;
        endcase
        return l;
    endfunction

    // active-high segments a..g in bits 0..6
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/multiplexed_seven_segment_scan_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scan_core
// Scans a decimal number across a multiplexed seven-segment display, one
// digit per refresh transaction, with leading-zero suppression.
// ----------------------------------------------------------------------------
// datapath: input register loaded on the accepting edge, then the result
//   register via the single-pass digit path
// throughput: one transaction per cycle unless m_tready stalls the output
// reset: scan position 0, max_value 9999, both pipeline stages empty
module multiplexed_seven_segment_scan_core #(
    parameter int NUM_DIGITS = mss_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // number[13:0], point_flags[17:14], min_width[20:18], zero pad [23:21]
    input  wire logic [mss_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // digit_select[3:0], segments[10:4], point_on[11], zero pad [15:12]
    output logic [mss_pkg::M_TDATA_W-1:0]          m_tdata,
    // error[0]
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [mss_pkg::NUMBER_W-1:0]      cfg_wdata
);

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic                              in_valid_reg;
    logic [mss_pkg::NUMBER_W-1:0]      number_reg;
    logic [mss_pkg::POINTS_W-1:0]      points_reg;
    logic [mss_pkg::MIN_WIDTH_W-1:0]   width_reg;
    logic                              out_valid_reg;
    logic                              out_error_reg;
    mss_pkg::disp_t                    out_disp_reg;
    mss_pkg::disp_t                    out_disp_next;
    logic [POS_W-1:0]                  pos_reg;
    logic [POS_W-1:0]                  pos_next;
    logic [mss_pkg::NUMBER_W-1:0]      max_value_reg;

    logic                              advance;
    logic                              error;
    mss_pkg::disp_t                    disp;
    logic [POS_W-1:0]                  scan_next;

    mss_digit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digit (
        .number_i      (number_reg),
        .point_flags_i (points_reg),
        .min_width_i   (width_reg),
        .pos_i         (pos_reg),
        .disp_o        (disp),
        .next_pos_o    (scan_next)
    );

    always_comb begin
        advance       = !out_valid_reg || m_tready;
        s_tready      = !in_valid_reg || advance;
        error         = number_reg > max_value_reg;
        // a rejected number blanks the outputs and holds the scan position
        out_disp_next = error ? '0 : disp;
        pos_next      = error ? pos_reg : scan_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            max_value_reg <= mss_pkg::MAX_VALUE_RST;
        end else begin
            if (cfg_we) begin
                max_value_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    pos_reg <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            number_reg <= s_tdata[13:0];
            points_reg <= s_tdata[17:14];
            width_reg  <= s_tdata[20:18];
        end
        if (advance && in_valid_reg) begin
            out_error_reg <= error;
            out_disp_reg  <= out_disp_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_error_reg;
    assign m_tdata  = {4'b0000, out_disp_reg};

endmodule
`default_nettype wire

// ----- rtl/mss_digit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mss_digit
// Picks the scan position, extracts its decimal digit and decodes it.
// ----------------------------------------------------------------------------
module mss_digit #(
    parameter int NUM_DIGITS = mss_pkg::NUM_DIGITS_DEF,
    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  wire logic [mss_pkg::NUMBER_W-1:0]    number_i,
    input  wire logic [mss_pkg::POINTS_W-1:0]    point_flags_i,
    input  wire logic [mss_pkg::MIN_WIDTH_W-1:0] min_width_i,
    input  wire logic [POS_W-1:0]                pos_i,
    output mss_pkg::disp_t                       disp_o,
    output logic [POS_W-1:0]                     next_pos_o
);

    logic [POS_W-1:0]                cur_pos;
    logic [POS_W-1:0]                eff_pos;
    logic [POS_W:0]                  eff_pos1;
    logic [mss_pkg::LIM_W-1:0]       lim;
    logic                            below;
    logic                            past_width;
    logic [mss_pkg::RECIP_W-1:0]     m_lo;
    logic [mss_pkg::RECIP_W-1:0]     m_hi;
    logic [mss_pkg::PROD_W-1:0]      p_lo;
    logic [mss_pkg::PROD_W-1:0]      p_hi;
    logic [mss_pkg::NUMBER_W-1:0]    q_lo;
    logic [mss_pkg::NUMBER_W-1:0]    q_hi;
    logic [mss_pkg::NUMBER_W-1:0]    rem;
    logic [7:0]                      onehot;

    always_comb begin
        cur_pos = ({1'b0, pos_i} >= (POS_W+1)'(NUM_DIGITS)) ? '0 : pos_i;

        // number / 10^pos is zero exactly when number < 10^pos
        lim        = mss_pkg::pow10_lim(mss_pkg::exp_t'(cur_pos));
        below      = {3'b000, number_i} < lim;
        past_width = mss_pkg::exp_t'(cur_pos) >= {1'b0, min_width_i};
        eff_pos    = (below && past_width) ? '0 : cur_pos;
        eff_pos1   = {1'b0, eff_pos} + (POS_W+1)'(1);

        // two quotients in parallel, digit is the low one minus ten times the high one
        m_lo = mss_pkg::recip_of(mss_pkg::exp_t'(eff_pos));
        m_hi = mss_pkg::recip_of(mss_pkg::exp_t'(eff_pos1));
        p_lo = mss_pkg::PROD_W'(number_i) * mss_pkg::PROD_W'(m_lo);
        p_hi = mss_pkg::PROD_W'(number_i) * mss_pkg::PROD_W'(m_hi);
        q_lo = p_lo[mss_pkg::RECIP_SHIFT +: mss_pkg::NUMBER_W];
        q_hi = p_hi[mss_pkg::RECIP_SHIFT +: mss_pkg::NUMBER_W];
        rem  = q_lo - ((q_hi << 3) + (q_hi << 1));

        onehot              = 8'(1) << eff_pos;
        disp_o.digit_select = onehot[mss_pkg::SEL_W-1:0];
        disp_o.segments     = mss_pkg::seg_of(rem[3:0]);
        disp_o.point_on     = |(point_flags_i & onehot[mss_pkg::SEL_W-1:0]);

        next_pos_o = (eff_pos1 == (POS_W+1)'(NUM_DIGITS)) ? '0 : eff_pos1[POS_W-1:0];
    end

endmodule
`default_nettype wire

// ----- tb/multiplexed_seven_segment_scan_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scan_core_tb
// Self-checking bench for the seven-segment scan core. Refresh ticks go in
// through a bursty stream driver. A local scan model tracks the digit position
// and the max_value limit and predicts each result transaction. The monitor
// stalls the result side on changing patterns, including one long hold-off.
// Stimulus covers all max_value extremes, leading-zero wrap, min_width beyond
// the digit count, rejected numbers and numbers wider than four digits.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scan_core_tb;

    localparam int NUM_DIGITS     = mss_pkg::NUM_DIGITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 200;
    localparam int MAX_REPORTS    = 10;

    // segments a..g for digits 0..9, digit 0 in the low bits
    localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                      7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    typedef struct packed {
        logic            err;
        mss_pkg::disp_t  disp;
    } scan_result_t;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic [mss_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [mss_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                              m_tuser;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [mss_pkg::NUMBER_W-1:0]      cfg_wdata = '0;

    // scan model state
    logic [mss_pkg::NUMBER_W-1:0]      limit_value = mss_pkg::MAX_VALUE_RST;
    logic [2:0]                        scan_pos    = '0;

    logic [mss_pkg::S_TDATA_W-1:0]     refresh_tick_q[$];
    scan_result_t                      predicted_scan_q[$];

    int unsigned mismatch_cnt  = 0;
    int unsigned results_seen  = 0;
    int unsigned idle_cycles   = 0;

    multiplexed_seven_segment_scan_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // one refresh tick through the scan model, advancing the digit position unless rejected
    function automatic scan_result_t predict_scan(input logic [13:0] number,
                                                  input logic [3:0] points,
                                                  input logic [2:0] min_width);
        scan_result_t r;
        int unsigned pos;
        int unsigned divider;
        int unsigned digit;
        r = '0;
        if (number > limit_value) begin
            r.err = 1'b1;
            return r;
        end
        pos = scan_pos;
        if (pos >= NUM_DIGITS)
            pos = 0;
        divider = 1;
        for (int i = 0; i < pos; i++)
            divider = divider * 10;
        // leading-zero suppression wraps back to the rightmost digit
        if (pos >= min_width && number / divider == 0) begin
            pos = 0;
            divider = 1;
        end
        digit = (number / divider) % 10;
        r.disp.segments = GLYPHS[digit*7 +: 7];
        if (pos < 4) begin
            r.disp.digit_select = 4'(1 << pos);
            r.disp.point_on     = points[pos];
        end
        pos = pos + 1;
        if (pos >= NUM_DIGITS)
            pos = 0;
        scan_pos = 3'(pos);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch on %s: expected 0x%0h, actual 0x%0h", what, want, got);
    endtask

    task automatic queue_tick(input int unsigned number, input int unsigned points,
                              input int unsigned min_width);
        refresh_tick_q.push_back({3'b000, 3'(min_width), 4'(points), 14'(number)});
    endtask

    // mostly display-like runs of one number, plus rejects and raw noise
    task automatic queue_random_ticks(input int unsigned count);
        int unsigned queued;
        int unsigned kind;
        int unsigned run_len;
        int unsigned number;
        int unsigned width;
        int unsigned points;
        int unsigned lo;
        int unsigned hi;
        queued = 0;
        while (queued < count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                case ($urandom_range(0, 4))
                    0:       begin lo = 0;     hi = 9;     end
                    1:       begin lo = 10;    hi = 99;    end
                    2:       begin lo = 100;   hi = 999;   end
                    3:       begin lo = 1000;  hi = 9999;  end
                    default: begin lo = 10000; hi = 16383; end
                endcase
                number = $urandom_range(lo, hi);
                if (number > limit_value && $urandom_range(0, 3) != 0)
                    number = number % (limit_value + 1);
                width  = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(0, 4);
                points = $urandom_range(0, 15);
                run_len = $urandom_range(2, 8);
                repeat (run_len) queue_tick(number, points, width);
                queued += run_len;
            end else if (kind == 7) begin
                // number above the limit when one exists, scan position must hold
                number = (limit_value < 16383) ? $urandom_range(limit_value + 1, 16383)
                                               : $urandom_range(0, 16383);
                queue_tick(number, $urandom_range(0, 15), $urandom_range(0, 7));
                queued++;
            end else begin
                queue_tick($urandom_range(0, 16383), $urandom_range(0, 15),
                           $urandom_range(0, 7));
                queued++;
            end
        end
    endtask

    task automatic wait_all_shown();
        while (refresh_tick_q.size() != 0 || s_tvalid || predicted_scan_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_limit(input logic [13:0] value);
        @(posedge aclk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        limit_value = value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
    endtask

    // stream driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin : tick_driver
        logic                          offer;
        logic [mss_pkg::S_TDATA_W-1:0] word;
        int unsigned                   burst_left;
        int unsigned                   gap_left;
        offer = s_tvalid;
        word  = s_tdata;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_scan_q.push_back(predict_scan(s_tdata[13:0], s_tdata[17:14],
                                                        s_tdata[20:18]));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (refresh_tick_q.size() > 0) begin
                    word  = refresh_tick_q.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_tvalid <= offer;
            s_tdata  <= word;
        end
    end

    // result monitor and ready pattern
    always @(posedge aclk) begin : result_monitor
        scan_result_t   want;
        mss_pkg::disp_t got;
        ready_mode_t    mode;
        int unsigned    mode_left;
        int unsigned    hold_left;
        logic           long_hold_done;
        if (!aresetn) begin
            m_tready       <= 1'b0;
            mode           = READY_ALWAYS;
            mode_left      = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = mss_pkg::disp_t'(m_tdata[11:0]);
                if (predicted_scan_q.size() == 0) begin
                    flag_mismatch("unexpected transaction", 0, m_tdata);
                end else begin
                    want = predicted_scan_q.pop_front();
                    if (m_tuser !== want.err)
                        flag_mismatch("error", want.err, m_tuser);
                    if (got.digit_select !== want.disp.digit_select)
                        flag_mismatch("digit_select", want.disp.digit_select,
                                      got.digit_select);
                    if (got.segments !== want.disp.segments)
                        flag_mismatch("segments", want.disp.segments, got.segments);
                    if (got.point_on !== want.disp.point_on)
                        flag_mismatch("point_on", want.disp.point_on, got.point_on);
                end
            end
            // one long hold-off while the driver keeps pushing
            if (results_seen >= 300 && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end else begin
                    mode_left--;
                end
                case (mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_RANDOM:   m_tready <= ($urandom_range(0, 1) == 1);
                    READY_PERIODIC: m_tready <= (mode_left % 3 != 0);
                    default:        m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit: boundaries, every digit glyph, wrap and wide min_width
        queue_tick(0, 0, 0);
        queue_tick(0, 4'hF, 1);
        repeat (4) queue_tick(9999, 4'hF, 4);
        queue_tick(10000, 4'hF, 0);
        queue_tick(16383, 4'hF, 7);
        repeat (4) queue_tick(1234, 4'h5, 7);
        repeat (4) queue_tick(5678, 4'hA, 0);
        repeat (3) queue_tick(90, 4'h2, 0);
        repeat (3) queue_tick(7, 4'h8, 3);
        queue_random_ticks(380);
        wait_all_shown();

        // only zero passes
        program_limit(14'd0);
        queue_random_ticks(120);
        wait_all_shown();

        // everything passes, five-digit numbers show their low digits
        program_limit(14'd16383);
        queue_tick(16383, 4'hF, 4);
        queue_tick(10000, 4'h0, 0);
        queue_random_ticks(260);
        wait_all_shown();

        program_limit(14'($urandom_range(1, 9998)));
        queue_random_ticks(220);
        wait_all_shown();

        program_limit(14'd9999);
        queue_random_ticks(250);
        wait_all_shown();

        repeat (8) @(posedge aclk);
        if (predicted_scan_q.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/mss_pkg.sv
rtl/mss_digit.sv
rtl/multiplexed_seven_segment_scan_core.sv
tb/multiplexed_seven_segment_scan_core_tb.sv
